// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the transcoder RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define U16U8_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property whose consequence must hold in the cycle after its condition.
`define U16U8_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/u16u8_pkg.sv =====
// ---------------------------------------------------------------------------
// u16u8_pkg
// Types and constants shared by the UTF-16LE to UTF-8 transcoder modules.
// ---------------------------------------------------------------------------
package u16u8_pkg;

  // Cipher selections for the unit descrambler.
  localparam logic [1:0] CIPHER_NONE = 2'd0;
  localparam logic [1:0] CIPHER_XOR  = 2'd1;
  localparam logic [1:0] CIPHER_SWAP = 2'd2;

  // Status codes carried on error items.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ODD     = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  // One command from the front end to the encoder back end.
  typedef struct packed {
    logic        is_data;  // 1: code point to encode, 0: single flag item
    logic [20:0] cp;       // code point
    logic [1:0]  nm1;      // number of output bytes minus one
    logic [1:0]  status;   // status of a flag item
    logic        done;     // last command of the message
  } cmd_t;

endpackage

// ===== hw/rtl/u16u8_front.sv =====
// ---------------------------------------------------------------------------
// u16u8_front
// Pairs input bytes into code units, descrambles them, tracks surrogates and
// errors, and issues one encoder command per byte that has results.
// ---------------------------------------------------------------------------
module u16u8_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] in_byte
  input  logic              s_axis_tlast,   // last_byte
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data,       // [1:0] cipher_mode
  input  logic              q_full,
  output logic              q_push,
  output u16u8_pkg::cmd_t   q_cmd
);
  import u16u8_pkg::*;

  logic [1:0]  cipher_mode;
  logic [7:0]  held_low_byte;
  logic        byte_phase;
  logic [9:0]  pending_high;
  logic        have_high;
  logic        error_seen;

  logic        accept;
  logic [15:0] unit_raw;
  logic [15:0] unit;
  logic        is_high;
  logic        is_low;
  logic [20:0] cp;

  logic        byte_phase_next;
  logic        have_high_next;
  logic        error_seen_next;
  logic        load_low;
  logic        load_high;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Descramble the completed unit with the selected cipher.
  assign unit_raw = {s_axis_tdata, held_low_byte};
  always_comb begin
    unit = unit_raw;
    case (cipher_mode)
      CIPHER_XOR: begin
        if (unit_raw >= 16'h0020) begin
          unit = unit_raw ^ {unit_raw[7:1], 8'h00, 1'b1};
        end
      end
      CIPHER_SWAP: begin
        for (int k = 0; k < 8; k++) begin
          unit[2*k]   = unit_raw[2*k+1];
          unit[2*k+1] = unit_raw[2*k];
        end
      end
      default: begin
        unit = unit_raw;
      end
    endcase
  end

  assign is_high = (unit[15:10] == 6'b110110);
  assign is_low  = (unit[15:10] == 6'b110111);

  // Code point: a surrogate pair joins with the held high half.
  assign cp = have_high ? (21'h10000 + {1'b0, pending_high, unit[9:0]}) : {5'd0, unit};

  // Classify the accepted byte and build the command.
  always_comb begin
    byte_phase_next = byte_phase;
    have_high_next  = have_high;
    error_seen_next = error_seen;
    load_low        = 1'b0;
    load_high       = 1'b0;
    q_push          = 1'b0;
    q_cmd.is_data   = 1'b0;
    q_cmd.cp        = cp;
    q_cmd.status    = ST_OK;
    q_cmd.done      = s_axis_tlast;
    if (cp[20:16] != 5'd0) begin
      q_cmd.nm1 = 2'd3;
    end else if (cp[15:11] != 5'd0) begin
      q_cmd.nm1 = 2'd2;
    end else if (cp[10:7] != 4'd0) begin
      q_cmd.nm1 = 2'd1;
    end else begin
      q_cmd.nm1 = 2'd0;
    end

    if (accept) begin
      if (error_seen) begin
        // Dropping until the message ends.
      end else if (!byte_phase) begin
        if (s_axis_tlast) begin
          q_push       = 1'b1;
          q_cmd.status = ST_ODD;
        end else begin
          load_low        = 1'b1;
          byte_phase_next = 1'b1;
        end
      end else begin
        byte_phase_next = 1'b0;
        if (have_high) begin
          if (is_low) begin
            have_high_next = 1'b0;
            q_push         = 1'b1;
            q_cmd.is_data  = 1'b1;
          end else begin
            error_seen_next = 1'b1;
            q_push          = 1'b1;
            q_cmd.status    = ST_INVALID;
          end
        end else if (is_high) begin
          if (s_axis_tlast) begin
            q_push       = 1'b1;
            q_cmd.status = ST_TRUNC;
          end else begin
            load_high      = 1'b1;
            have_high_next = 1'b1;
          end
        end else if (is_low) begin
          error_seen_next = 1'b1;
          q_push          = 1'b1;
          q_cmd.status    = ST_INVALID;
        end else if (unit != 16'h0000) begin
          q_push        = 1'b1;
          q_cmd.is_data = 1'b1;
        end
      end

      // The final byte always leaves one item and clears the message state.
      if (s_axis_tlast) begin
        q_push          = 1'b1;
        byte_phase_next = 1'b0;
        have_high_next  = 1'b0;
        error_seen_next = 1'b0;
      end
    end

    if (!q_cmd.is_data) begin
      q_cmd.nm1 = 2'd0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_mode <= CIPHER_NONE;
      byte_phase  <= 1'b0;
      have_high   <= 1'b0;
      error_seen  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cipher_mode <= cfg_data;
      end
      byte_phase <= byte_phase_next;
      have_high  <= have_high_next;
      error_seen <= error_seen_next;
    end
  end

  // Held halves of a unit and of a surrogate pair.
  always_ff @(posedge clk) begin
    if (load_low) begin
      held_low_byte <= s_axis_tdata;
    end
    if (load_high) begin
      pending_high <= unit[9:0];
    end
  end

endmodule

// ===== hw/rtl/u16u8_fifo.sv =====
// ---------------------------------------------------------------------------
// u16u8_fifo
// Short command queue between the front end and the encoder back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module u16u8_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u16u8_pkg::cmd_t   wr_cmd,
  output logic              full,
  input  logic              pop,
  output u16u8_pkg::cmd_t   head,
  output logic              empty
);
  import u16u8_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `U16U8_ASSERT(a_count_range, clk, rst, count <= CW'(DEPTH), "queue count overflow")
  `U16U8_ASSERT(a_no_push_full, clk, rst, !(push && full), "push into a full queue")
  `U16U8_ASSERT(a_no_pop_empty, clk, rst, !(pop && empty), "pop from an empty queue")
  `U16U8_ASSERT_NEXT(a_push_fills, clk, rst, push && !pop, !empty, "pushed item lost")

endmodule

// ===== hw/rtl/u16u8_back.sv =====
// ---------------------------------------------------------------------------
// u16u8_back
// Expands queued commands into UTF-8 bytes in an output register, one per
// cycle while that register is free.
// ---------------------------------------------------------------------------
module u16u8_back (
  input  logic              clk,
  input  logic              rst,
  input  u16u8_pkg::cmd_t   head,
  input  logic              empty,
  output logic              pop,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [7:0] out_byte
  output logic              m_axis_tlast,   // last_of_run
  output logic [3:0]        m_axis_tuser    // [0] byte_valid, [1] message_done, [3:2] status
);
  import u16u8_pkg::*;

  logic [1:0] idx;
  logic       out_free;
  logic       take;
  logic       final_byte;

  // Byte idx of a code point encoded in nm1 + 1 bytes.
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] nm1,
                                            input logic [1:0] pos);
    logic [7:0] b;
    case ({nm1, pos})
      4'b00_00: b = {1'b0, cp[6:0]};
      4'b01_00: b = {3'b110, cp[10:6]};
      4'b01_01: b = {2'b10, cp[5:0]};
      4'b10_00: b = {4'b1110, cp[15:12]};
      4'b10_01: b = {2'b10, cp[11:6]};
      4'b10_10: b = {2'b10, cp[5:0]};
      4'b11_00: b = {5'b11110, cp[20:18]};
      4'b11_01: b = {2'b10, cp[17:12]};
      4'b11_10: b = {2'b10, cp[11:6]};
      4'b11_11: b = {2'b10, cp[5:0]};
      default:  b = 8'h00;
    endcase
    return b;
  endfunction

  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign take       = !empty && out_free;
  assign final_byte = (idx == head.nm1);
  assign pop        = take && final_byte;

  // Byte counter within the head command, and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (take) begin
        idx <= final_byte ? 2'd0 : idx + 2'd1;
      end
      if (out_free) begin
        m_axis_tvalid <= !empty;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tlast <= final_byte;
      if (head.is_data) begin
        m_axis_tdata <= utf8_byte(head.cp, head.nm1, idx);
        m_axis_tuser <= {ST_OK, head.done && final_byte, 1'b1};
      end else begin
        m_axis_tdata <= 8'h00;
        m_axis_tuser <= {head.status, head.done, 1'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/utf16le_cipher_to_utf8.sv =====
// ---------------------------------------------------------------------------
// utf16le_cipher_to_utf8
// UTF-16LE to UTF-8 transcoder with a selectable unit descrambler.
// ---------------------------------------------------------------------------
// Input stream s_axis carries one message byte per item, tlast on the final
// byte. Output stream m_axis carries one result per item: tdata is the UTF-8
// byte, tlast marks the last result caused by one input byte, and tuser holds
// byte_valid, message_done and status. Error and end markers have
// byte_valid 0. The cfg channel writes the cipher mode; cfg_ready is always
// high. The user writes it only while the block is idle; the block does not enforce it.
// The byte that completes a code point is written into the command queue;
// the first output byte then moves from the queue into the output register.
// Throughput: the front end takes one input byte per cycle while the
// command queue has room; the encoder emits one output byte per cycle while
// the output register is free, and a code point gives one to four bytes.
// Reset clears the unit and surrogate state, empties the queue and selects
// no scrambling. When the receiver stalls, the output register holds its
// item, the queue fills, and then s_axis_tready drops.
// ---------------------------------------------------------------------------
module utf16le_cipher_to_utf8 #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // last_of_run
  output logic [3:0] m_axis_tuser,   // [0] byte_valid, [1] message_done, [3:2] status
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data        // [1:0] cipher_mode
);
  import u16u8_pkg::*;

  cmd_t q_cmd;
  cmd_t q_head;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  // Byte pairing, descrambling and classification.
  u16u8_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  // Command queue.
  u16u8_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_cmd (q_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .head   (q_head),
    .empty  (q_empty)
  );

  // UTF-8 encoder and output register.
  u16u8_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .empty         (q_empty),
    .pop           (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== verif/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: UTF-16LE to UTF-8 transcoder testbench
// Feeds the transcoder little-endian UTF-16 message bodies over the input
// stream and checks every output item against an in-bench transcoder model.
// A short directed table covers the encoding ranges and each error path. It
// is followed by random messages under every cipher setting, with random
// gaps on both streams and one long receiver stall that backs up the input.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import u16u8_pkg::*;

  // Reserved cipher code, expected to behave as no scrambling.
  localparam logic [1:0] CIPHER_RSVD = 2'd3;
  localparam int HOLD_CYCLES  = 250;
  localparam int IDLE_SETTLE  = 12;
  localparam int RANDOM_BYTES = 160;

  // One output item as seen on m_axis.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       run_end;
    logic       msg_end;
    logic [1:0] status;
  } utf8_res_t;

  // One row of the directed table.
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    utf8_res_t  res;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic [3:0] m_axis_tuser;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_data;

  // Typed expectation that travels with the byte currently offered.
  logic       in_typed;
  utf8_res_t  in_res;

  // Model state.
  logic [1:0] cipher_sel;
  logic [7:0] lo_byte;
  logic       odd_phase;
  logic [9:0] hi_pending;
  logic       hi_held;
  logic       drop_rest;

  utf8_res_t  want_q[$];
  utf8_res_t  step_q[$];
  logic [7:0] msg_bytes[$];
  stim_row_t  dir_tab[$];

  int  errors;
  int  bytes_in;
  int  bytes_out;
  int  phases;
  bit  full_speed;
  bit  hold_req;

  utf16le_cipher_to_utf8 dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] in_byte
    .s_axis_tlast  (s_axis_tlast),   // last_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte
    .m_axis_tlast  (m_axis_tlast),   // last_of_run
    .m_axis_tuser  (m_axis_tuser),   // [0] byte_valid, [1] message_done, [3:2] status
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)        // [1:0] cipher_mode
  );

  // Free-running clock, 20 ns period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Transcoder model
  // ------------------------------------------------------------------------

  function automatic utf8_res_t make_res(logic [7:0] d, logic v, logic [1:0] st);
    utf8_res_t r;
    r = '0;
    r.data = d;
    r.valid = v;
    r.status = st;
    return r;
  endfunction

  // Appends one item to the results of the current step.
  function automatic void add_step(utf8_res_t r);
    step_q.insert(step_q.size(), r);
  endfunction

  function automatic logic [15:0] descramble_unit(logic [15:0] u);
    logic [15:0] w;
    w = u;
    case (cipher_sel)
      CIPHER_XOR: begin
        if (u >= 16'h0020) w = u ^ {u[7:1], 1'b0, 8'h01};
      end
      CIPHER_SWAP: begin
        w = ((u & 16'haaaa) >> 1) | ((u & 16'h5555) << 1);
      end
      default: w = u;
    endcase
    return w;
  endfunction

  // Inverse of the descrambler, so that random messages come out well formed.
  function automatic logic [15:0] scramble_unit(logic [15:0] d);
    logic [15:0] e;
    e = d;
    case (cipher_sel)
      CIPHER_XOR: begin
        e = {d[15:8] ^ {d[7:1], 1'b0}, d[7:0] ^ 8'h01};
        if (e < 16'h0020) e = d;
      end
      CIPHER_SWAP: e = ((d & 16'haaaa) >> 1) | ((d & 16'h5555) << 1);
      default: e = d;
    endcase
    return e;
  endfunction

  task automatic encode_cp(input logic [20:0] cp);
    if (cp <= 21'h7f) begin
      add_step(make_res(cp[7:0], 1'b1, ST_OK));
    end else if (cp <= 21'h7ff) begin
      add_step(make_res({3'b110, cp[10:6]}, 1'b1, ST_OK));
      add_step(make_res({2'b10, cp[5:0]}, 1'b1, ST_OK));
    end else if (cp <= 21'hffff) begin
      add_step(make_res({4'b1110, cp[15:12]}, 1'b1, ST_OK));
      add_step(make_res({2'b10, cp[11:6]}, 1'b1, ST_OK));
      add_step(make_res({2'b10, cp[5:0]}, 1'b1, ST_OK));
    end else begin
      add_step(make_res({5'b11110, cp[20:18]}, 1'b1, ST_OK));
      add_step(make_res({2'b10, cp[17:12]}, 1'b1, ST_OK));
      add_step(make_res({2'b10, cp[11:6]}, 1'b1, ST_OK));
      add_step(make_res({2'b10, cp[5:0]}, 1'b1, ST_OK));
    end
  endtask

  task automatic clear_unit_state();
    lo_byte = '0;
    odd_phase = 1'b0;
    hi_pending = '0;
    hi_held = 1'b0;
    drop_rest = 1'b0;
  endtask

  // Works out the output items that one accepted input byte causes.
  task automatic transcode_byte(input logic [7:0] b, input logic last);
    logic [15:0] u;
    step_q.delete();
    if (drop_rest) begin
      // Rest of the message is dropped after an error.
    end else if (!odd_phase) begin
      if (last) add_step(make_res(8'h00, 1'b0, ST_ODD));
      else begin
        lo_byte = b;
        odd_phase = 1'b1;
      end
    end else begin
      u = descramble_unit({b, lo_byte});
      odd_phase = 1'b0;
      if (hi_held) begin
        if (u >= 16'hdc00 && u <= 16'hdfff) begin
          hi_held = 1'b0;
          encode_cp(21'h10000 + {1'b0, hi_pending, u[9:0]});
        end else begin
          drop_rest = 1'b1;
          add_step(make_res(8'h00, 1'b0, ST_INVALID));
        end
      end else if (u >= 16'hd800 && u <= 16'hdbff) begin
        if (last) add_step(make_res(8'h00, 1'b0, ST_TRUNC));
        else begin
          hi_pending = u[9:0];
          hi_held = 1'b1;
        end
      end else if (u >= 16'hdc00 && u <= 16'hdfff) begin
        drop_rest = 1'b1;
        add_step(make_res(8'h00, 1'b0, ST_INVALID));
      end else if (u != 16'h0000) begin
        encode_cp({5'd0, u});
      end
    end

    if (last) begin
      if (step_q.size() == 0) add_step(make_res(8'h00, 1'b0, ST_OK));
      step_q[step_q.size() - 1].msg_end = 1'b1;
      clear_unit_state();
    end
    if (step_q.size() > 0) begin
      step_q[step_q.size() - 1].run_end = 1'b1;
    end
  endtask

  // ------------------------------------------------------------------------
  // Sampling at the rising edge: model update and output checking
  // ------------------------------------------------------------------------

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: mismatch on %s, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    utf8_res_t got;
    utf8_res_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        transcode_byte(s_axis_tdata, s_axis_tlast);
        if (in_typed) want_q.insert(want_q.size(), in_res);
        else foreach (step_q[i]) want_q.insert(want_q.size(), step_q[i]);
        bytes_in++;
      end
      if (cfg_valid && cfg_ready) cipher_sel = cfg_data;
      if (m_axis_tvalid && m_axis_tready) begin
        got.data = m_axis_tdata;
        got.valid = m_axis_tuser[0];
        got.run_end = m_axis_tlast;
        got.msg_end = m_axis_tuser[1];
        got.status = m_axis_tuser[3:2];
        bytes_out++;
        if (want_q.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected output item, got data 0x%0h user 0x%0h last %0b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          want = want_q.pop_front();
          check_field("out_byte", want.data, got.data);
          check_field("byte_valid", want.valid, got.valid);
          check_field("last_of_run", want.run_end, got.run_end);
          check_field("message_done", want.msg_end, got.msg_end);
          check_field("status", want.status, got.status);
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(15, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic int sender_gap();
    if (full_speed || $urandom_range(0, 9) < 5) return 0;
    return gap_len();
  endfunction

  // Offers one byte and waits until it is accepted. Called at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input utf8_res_t res);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tlast = last;
    in_typed = typed;
    in_res = res;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Stops the input and waits until every expected item has come out.
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    in_typed = 1'b0;
    while (want_q.size() != 0) @(negedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  task automatic write_cipher(input logic [1:0] mode);
    cfg_valid = 1'b1;
    cfg_data = mode;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_unit(input logic [15:0] d, input bit raw);
    logic [15:0] e;
    e = raw ? d : scramble_unit(d);
    msg_bytes.insert(msg_bytes.size(), e[7:0]);
    msg_bytes.insert(msg_bytes.size(), e[15:8]);
  endtask

  // Builds one message of code units and sends it. A message that is not
  // clean may hold raw units, stray or lone surrogates, and a broken end.
  task automatic send_message(input int n_units, input bit clean);
    logic [15:0] d;
    msg_bytes.delete();
    for (int i = 0; i < n_units; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_unit(16'($urandom_range(1, 16'h7f)), 1'b0);
        3: add_unit(16'($urandom_range(16'h80, 16'h7ff)), 1'b0);
        4: begin
          d = 16'($urandom_range(16'h800, 16'hffff));
          if (d >= 16'hd800 && d <= 16'hdfff) d = d ^ 16'h4000;
          add_unit(d, 1'b0);
        end
        5, 6: begin
          add_unit(16'hd800 | 16'($urandom_range(0, 1023)), 1'b0);
          add_unit(16'hdc00 | 16'($urandom_range(0, 1023)), 1'b0);
        end
        7: add_unit(16'h0000, 1'b0);
        default: begin
          if (clean) add_unit(16'($urandom_range(16'h20, 16'h7e)), 1'b0);
          else begin
            case ($urandom_range(0, 2))
              0: add_unit(16'($urandom_range(0, 16'hffff)), 1'b1);
              1: add_unit(16'hdc00 | 16'($urandom_range(0, 1023)), 1'b0);
              default: add_unit(16'hd800 | 16'($urandom_range(0, 1023)), 1'b0);
            endcase
          end
        end
      endcase
    end
    // Broken message end: an odd trailing byte or a cut-off high surrogate.
    if (!clean) begin
      case ($urandom_range(0, 2))
        0: msg_bytes.insert(msg_bytes.size(), 8'($urandom));
        1: add_unit(16'hd800 | 16'($urandom_range(0, 1023)), 1'b0);
        default: ;
      endcase
    end
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, '0);
  endtask

  // A message of arbitrary bytes.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 9);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1, 1'b0, '0);
  endtask

  function automatic stim_row_t row(logic [7:0] b, logic last, logic typed, logic [7:0] d,
                                    logic v, logic re, logic me, logic [1:0] st);
    stim_row_t r;
    r.b = b;
    r.last = last;
    r.typed = typed;
    r.res = '{data: d, valid: v, run_end: re, msg_end: me, status: st};
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Receiver: random ready pattern, plus one long hold-off on request
  // ------------------------------------------------------------------------
  initial begin
    forever begin
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (full_speed || $urandom_range(0, 3) != 0) begin
        m_axis_tready = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        m_axis_tready = 1'b0;
        repeat (gap_len()) @(negedge clk);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------
  initial begin
    logic [1:0] modes[6];
    int         random_bytes;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_typed = 1'b0;
    in_res = '0;
    errors = 0;
    bytes_in = 0;
    bytes_out = 0;
    phases = 0;
    full_speed = 1'b0;
    hold_req = 1'b0;
    cipher_sel = CIPHER_NONE;
    clear_unit_state();
    modes = '{CIPHER_XOR, CIPHER_SWAP, CIPHER_NONE, CIPHER_RSVD, CIPHER_SWAP, CIPHER_XOR};

    // Directed table, no scrambling after reset.
    dir_tab = '{
      row(8'h7f, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK),
      row(8'h00, 1'b0, 1'b1, 8'h7f, 1'b1, 1'b1, 1'b0, ST_OK),      // largest one-byte
      row(8'hff, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK),
      row(8'h07, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK),      // largest two-byte
      row(8'hff, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK),
      row(8'hff, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK),      // largest BMP unit
      row(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK),
      row(8'hd8, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK),
      row(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK),
      row(8'hdc, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK),      // first supplementary
      row(8'hff, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK),
      row(8'hdb, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK),
      row(8'hff, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK),
      row(8'hdf, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK),      // last code point
      row(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK),
      row(8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, ST_OK),      // zero unit at end
      row(8'h41, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, ST_ODD),     // odd size
      row(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK),
      row(8'hd8, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, ST_TRUNC),   // cut-off high
      row(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK),
      row(8'hdc, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0, ST_INVALID), // stray low
      row(8'h42, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, ST_OK),      // end after drop
      row(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK),
      row(8'hd8, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK),
      row(8'h41, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK),
      row(8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, ST_INVALID)  // high, then no low
    };

    repeat (2) @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].b, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].res);
    end
    wait_idle();

    // Random phases, one cipher setting each, written while the block is idle.
    random_bytes = bytes_in;
    while (bytes_in - random_bytes < RANDOM_BYTES || phases < 6) begin
      write_cipher(modes[phases % 6]);
      full_speed = (phases == 2);
      if (phases == 1) begin
        // Long receiver stall while a long message keeps coming.
        hold_req = 1'b1;
        send_message(12, 1'b1);
      end
      repeat (3) begin
        if ($urandom_range(0, 3) != 0) send_message($urandom_range(1, 6), 1'b1);
        else if ($urandom_range(0, 1) != 0) send_message($urandom_range(1, 5), 1'b0);
        else send_noise();
      end
      wait_idle();
      phases++;
    end
    write_cipher(CIPHER_NONE);
    send_message(3, 1'b1);
    wait_idle();

    $display("Sent %0d input bytes, checked %0d output items over %0d cipher phases.",
             bytes_in, bytes_out, phases + 1);
    $display("Directed table plus random messages, one long output stall, %0d mismatches.",
             errors);
    if (errors == 0 && want_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout with %0d items still expected.", want_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== utf16le_cipher_to_utf8.f =====
+incdir+hw/rtl
hw/rtl/u16u8_pkg.sv
hw/rtl/u16u8_front.sv
hw/rtl/u16u8_fifo.sv
hw/rtl/u16u8_back.sv
hw/rtl/utf16le_cipher_to_utf8.sv
verif/tb_top.sv
